// ===== hw/rtl/i8dq_pkg.sv =====
// Package for int8_dot_dequantize: payload structs, constants, float helpers.
// No dependencies.
`timescale 1ns / 1ps
package i8dq_pkg;

    localparam int LANES_DEF = 8;
    localparam int MAX_K_DEF = 65536;
    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    typedef struct packed {
        logic [63:0]        weight_bytes;
        logic [63:0]        activation_bytes;
        logic [3:0]         lanes_valid;
        logic               last_item;
        logic signed [7:0]  zero_point;
        logic signed [23:0] row_sum;
        logic [31:0]        weight_scale_bits;
        logic [31:0]        act_scale_bits;
    } t_in;

    typedef struct packed {
        logic [31:0] result_bits;
        logic        length_error;
    } t_out;

    typedef enum logic [2:0] {
        ST_ACC, ST_CONV, ST_MUL1, ST_RND1, ST_MUL2, ST_RND2, ST_OUT
    } t_state;

    // Round a positive magnitude given as (exponent of msb, 48-bit significand
    // with the leading one at bit 47) to binary32, handling subnormal, overflow.
    function automatic logic [31:0] fp_pack(input logic sgn, input logic signed [10:0] e,
                                            input logic [47:0] m);
        logic [72:0]       sh;
        logic [23:0]       kept;
        logic              g, st;
        logic [24:0]       r;
        logic signed [10:0] be;
        logic [5:0]        amt;
        sh = {m, 25'd0};
        be = e + 11'sd127;
        if (be < 11'sd1) begin
            amt = (11'sd1 - be > 11'sd40) ? 6'd40 : 6'(11'sd1 - be);
            sh = sh >> amt;
            be = 11'sd0;
        end
        kept = sh[72:49];
        g = sh[48];
        st = |sh[47:0];
        r = {1'b0, kept} + 25'(g & (st | kept[0]));
        if (r[24]) begin
            r = r >> 1;
            be = be + 11'sd1;
        end else if (be == 11'sd0 && r[23]) begin
            be = 11'sd1;
        end
        if (be >= 11'sd255) fp_pack = {sgn, 8'hFF, 23'd0};
        else fp_pack = {sgn, be[7:0], r[22:0]};
    endfunction

endpackage

// ===== hw/rtl/i8dq_lane.sv =====
// One multiply lane: signed byte product, masked by the valid lane count.
// Depends on nothing.
`timescale 1ns / 1ps
module i8dq_lane #(
    parameter int IDX = 0
) (
    input  logic [7:0]         i_w,
    input  logic [7:0]         i_a,
    input  logic [3:0]         i_n,
    output logic signed [16:0] o_prod
);
    logic signed [16:0] p;
    assign p = 17'($signed(i_w) * $signed(i_a));
    assign o_prod = (i_n > 4'(IDX)) ? p : 17'sd0;
endmodule

// ===== hw/rtl/i8dq_fmul.sv =====
// binary32 multiply, split: product stage then round/pack stage.
// Depends on i8dq_pkg.
`timescale 1ns / 1ps
module i8dq_fmul (
    input  logic        i_clk,
    input  logic        i_ld,
    input  logic        i_rnd,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_res
);
    logic [47:0] r_prod, n_prod;
    logic signed [10:0] r_exp, n_exp;
    logic r_sgn, r_spec;
    logic [31:0] r_sval, n_sval, r_res;
    logic [7:0] ea, eb;
    logic [23:0] ma, mb;
    logic na, nb, ia, ib, za, zb, sg;
    logic [5:0] lz;
    logic [47:0] nm;
    always_comb begin
        ea = i_a[30:23]; eb = i_b[30:23];
        ma = {ea != 8'd0, i_a[22:0]}; mb = {eb != 8'd0, i_b[22:0]};
        na = ea == 8'hFF && i_a[22:0] != 23'd0;
        nb = eb == 8'hFF && i_b[22:0] != 23'd0;
        ia = ea == 8'hFF && !na; ib = eb == 8'hFF && !nb;
        za = ma == 24'd0; zb = mb == 24'd0;
        sg = i_a[31] ^ i_b[31];
        n_prod = ma * mb;
        n_exp = 11'(signed'({3'd0, ea} + (ea == 8'd0 ? 11'd1 : 11'd0)))
              + 11'(signed'({3'd0, eb} + (eb == 8'd0 ? 11'd1 : 11'd0))) - 11'sd254 + 11'sd1;
        n_sval = '0;
        if (na || nb || (ia && zb) || (ib && za)) n_sval = i8dq_pkg::QNAN;
        else if (ia || ib) n_sval = {sg, 8'hFF, 23'd0};
        else if (za || zb) n_sval = {sg, 31'd0};
    end
    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_prod <= n_prod; r_exp <= n_exp; r_sgn <= sg;
            r_sval <= n_sval; r_spec <= n_sval != 32'd0 || za || zb;
        end
        if (i_rnd) r_res <= r_spec ? r_sval : i8dq_pkg::fp_pack(r_sgn, r_exp - 11'(lz), nm);
    end
    // leading-one normalize of the 48-bit product
    always_comb begin
        lz = 6'd0;
        for (int k = 0; k < 48; k++) if (r_prod[k]) lz = 6'(47 - k);
        nm = r_prod << lz;
    end
    assign o_res = r_res;
endmodule

// ===== hw/rtl/int8_dot_dequantize.sv =====
// Top level of the int8 dot product with float dequantize.
// Depends on i8dq_pkg, i8dq_lane, i8dq_fmul.
`timescale 1ns / 1ps
// Each request carries up to LANES byte pairs; the lanes multiply in parallel and an
// adder tree merges them into the running sum, one request per cycle. A request with
// last_item set closes the dot product: after it is taken, new requests stall through
// the convert, two float multiplies (a load and a round state each) and output states,
// longer while an earlier result is still waiting. The result sits in an output
// register until taken; length_error flags more than MAX_K elements.
module int8_dot_dequantize #(
    parameter int LANES = i8dq_pkg::LANES_DEF,
    parameter int MAX_K = i8dq_pkg::MAX_K_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  i8dq_pkg::t_in    i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output i8dq_pkg::t_out   o_data
);
    localparam int CW = $clog2(MAX_K + 1);
    i8dq_pkg::t_state r_st, n_st;
    logic r_asym;
    logic [31:0] r_acc, n_acc;
    logic [CW-1:0] r_cnt;
    logic r_ovf;
    logic signed [16:0] prod [LANES];
    logic [3:0] nv;
    logic signed [20:0] lsum;
    logic signed [40:0] r_dot;
    logic [31:0] r_ws, r_as, r_conv, r_res, fa, fb;
    logic r_err, r_oval, acc_en, ld, rnd;
    logic [CW:0] cnt_sum;
    logic [40:0] mag;
    logic [5:0] lz;
    logic [47:0] nm;
    logic [31:0] fres;

    assign nv = (i_data.lanes_valid > 4'(LANES)) ? 4'(LANES) : i_data.lanes_valid;
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        i8dq_lane #(.IDX(g)) u_lane (.i_w(i_data.weight_bytes[8*g +: 8]),
            .i_a(i_data.activation_bytes[8*g +: 8]), .i_n(nv), .o_prod(prod[g]));
    end
    always_comb begin
        lsum = '0;
        for (int k = 0; k < LANES; k++) lsum = lsum + 21'(prod[k]);
    end

    assign o_cfg_ready = 1'b1;
    assign o_stall = r_st != i8dq_pkg::ST_ACC;
    assign acc_en = i_valid && !o_stall;
    assign n_acc = r_acc + 32'(lsum);
    assign cnt_sum = (CW+1)'(r_cnt) + (CW+1)'(nv);

    always_comb begin
        n_st = r_st; ld = 1'b0; rnd = 1'b0; fa = r_conv; fb = r_ws;
        unique case (r_st)
            i8dq_pkg::ST_ACC:  if (acc_en && i_data.last_item) n_st = i8dq_pkg::ST_CONV;
            i8dq_pkg::ST_CONV: n_st = i8dq_pkg::ST_MUL1;
            i8dq_pkg::ST_MUL1: begin ld = 1'b1; n_st = i8dq_pkg::ST_RND1; end
            i8dq_pkg::ST_RND1: begin rnd = 1'b1; n_st = i8dq_pkg::ST_MUL2; end
            i8dq_pkg::ST_MUL2: begin ld = 1'b1; fa = fres; fb = r_as; n_st = i8dq_pkg::ST_RND2; end
            i8dq_pkg::ST_RND2: begin rnd = 1'b1; n_st = i8dq_pkg::ST_OUT; end
            i8dq_pkg::ST_OUT:  if (!r_oval || !i_stall) n_st = i8dq_pkg::ST_ACC;
            default:           n_st = i8dq_pkg::ST_ACC;
        endcase
    end

    i8dq_fmul u_fmul (.i_clk(i_clk), .i_ld(ld), .i_rnd(rnd), .i_a(fa), .i_b(fb),
        .o_res(fres));

    // int to float of the corrected dot product
    always_comb begin
        mag = r_dot[40] ? 41'(-r_dot) : 41'(r_dot);
        lz = 6'd0;
        for (int k = 0; k < 41; k++) if (mag[k]) lz = 6'(40 - k);
        nm = {mag << lz, 7'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= i8dq_pkg::ST_ACC; r_asym <= 1'b0; r_acc <= '0; r_cnt <= '0;
            r_ovf <= 1'b0; r_oval <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_valid) r_asym <= i_cfg_data;
            if (acc_en) begin
                if (i_data.last_item) begin
                    r_acc <= '0; r_cnt <= '0; r_ovf <= 1'b0;
                end else begin
                    r_acc <= n_acc;
                    if (cnt_sum > (CW+1)'(MAX_K)) begin
                        r_cnt <= CW'(MAX_K); r_ovf <= 1'b1;
                    end else r_cnt <= cnt_sum[CW-1:0];
                end
            end
            if (o_valid && !i_stall) r_oval <= 1'b0;
            if (r_st == i8dq_pkg::ST_OUT && (!r_oval || !i_stall)) r_oval <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_en && i_data.last_item) begin
            r_dot <= 41'($signed(n_acc)) - (r_asym ? 41'(i_data.zero_point * i_data.row_sum)
                                                   : 41'sd0);
            r_err <= r_ovf || cnt_sum > (CW+1)'(MAX_K);
            r_ws <= i_data.weight_scale_bits; r_as <= i_data.act_scale_bits;
        end
        if (r_st == i8dq_pkg::ST_CONV)
            r_conv <= (mag == 41'd0) ? 32'd0 : i8dq_pkg::fp_pack(r_dot[40], 11'(40 - 32'(lz)), nm);
        if (r_st == i8dq_pkg::ST_OUT && (!r_oval || !i_stall)) r_res <= fres;
    end

    logic r_eout;
    always_ff @(posedge i_clk)
        if (r_st == i8dq_pkg::ST_OUT && (!r_oval || !i_stall)) r_eout <= r_err;

    assign o_valid = r_oval;
    assign o_data = '{result_bits: r_res, length_error: r_eout};

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_en && i_data.last_item) |=> o_stall) else $error("no stall after last");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_K)) else $error("count past max");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped");
endmodule
